/* sv/scba_pkg.sv */
package scba_pkg;

  localparam int CHUNK_BYTES     = 16384;
  localparam int MAX_CHUNKS      = 64;
  localparam int NUM_CLASSES     = 14;
  localparam int MAX_CLASS_BYTES = 640;

  localparam int ADDR_W  = 20;
  localparam int LINK_W  = ADDR_W + 1;
  localparam int SLOT_W  = 16;
  localparam int SIZE_W  = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int CLASS_W = $clog2(NUM_CLASSES);
  localparam int BSZ_W   = $clog2(MAX_CLASS_BYTES + 1);
  localparam int OFF_W   = $clog2(CHUNK_BYTES);
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);

  localparam int IN_DATA_W  = ((CMD_W + SIZE_W + ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_W + STAT_W + 7) / 8) * 8;

  // Bit 20 of a head or link marks the end of a list.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(1) << ADDR_W;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] ST_ALLOCATED = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERSIZE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED     = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  localparam logic [BSZ_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
    BSZ_W'(16),  BSZ_W'(32),  BSZ_W'(64),  BSZ_W'(96),  BSZ_W'(128),
    BSZ_W'(160), BSZ_W'(192), BSZ_W'(224), BSZ_W'(256), BSZ_W'(320),
    BSZ_W'(384), BSZ_W'(448), BSZ_W'(512), BSZ_W'(640)
  };

  // Offset of the last whole block of a class within one chunk.
  localparam logic [OFF_W-1:0] CLASS_LAST_OFF [NUM_CLASSES] = '{
    OFF_W'((CHUNK_BYTES / 16) * 16 - 16),
    OFF_W'((CHUNK_BYTES / 32) * 32 - 32),
    OFF_W'((CHUNK_BYTES / 64) * 64 - 64),
    OFF_W'((CHUNK_BYTES / 96) * 96 - 96),
    OFF_W'((CHUNK_BYTES / 128) * 128 - 128),
    OFF_W'((CHUNK_BYTES / 160) * 160 - 160),
    OFF_W'((CHUNK_BYTES / 192) * 192 - 192),
    OFF_W'((CHUNK_BYTES / 224) * 224 - 224),
    OFF_W'((CHUNK_BYTES / 256) * 256 - 256),
    OFF_W'((CHUNK_BYTES / 320) * 320 - 320),
    OFF_W'((CHUNK_BYTES / 384) * 384 - 384),
    OFF_W'((CHUNK_BYTES / 448) * 448 - 448),
    OFF_W'((CHUNK_BYTES / 512) * 512 - 512),
    OFF_W'((CHUNK_BYTES / 640) * 640 - 640)
  };

endpackage

/* sv/size_class_block_allocator.sv */
// Size-class block allocator.
// Input channel (in_*): one command word per handshake, carrying the command,
// a size in bytes and, for a free, the block address. Output channel (out_*):
// exactly one result word per command, the allocated address and a status.
// Each command is taken into a small sequencer; the block drops in_tready
// until the command's result has been placed in the output register.
// Free, clear, zero-size, oversize, unused and exhausted commands pass through
// the EXEC and DONE states; an allocate from a non-empty list adds a POP state
// between them, since the link of the popped block comes from the link RAM
// through its registered read port. An allocate that carves a new chunk stays in
// CARVE and writes one link per cycle through the single RAM write port, one for
// every block of the 16 KiB chunk, before it goes on to DONE.
// The output register lets the next command be accepted while a result waits.
// If out_tready stays low with a result still waiting, the finished result of
// the next command is held inside and the input side stays stalled.
// Reset empties all free lists and returns every chunk; the link RAM is not
// cleared, as each link is written before it can be read.
module size_class_block_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] command, [17:2] size, [37:18] address, upper bits zero
  input  logic [scba_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [19:0] address_res, [22:20] status, upper bits zero
  output logic [scba_pkg::OUT_DATA_W-1:0] out_tdata
);
  import scba_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_CARVE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_r;
  logic [LINK_W-1:0]  heads_r [NUM_CLASSES];
  logic [CNT_W-1:0]   chunks_r;
  logic [ADDR_W-1:0]  base_r;
  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [STAT_W-1:0]  out_stat_r;

  logic [CMD_W-1:0]   cmd_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [CLASS_W-1:0] cls_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic [STAT_W-1:0]  res_stat_r;
  logic [ADDR_W-1:0]  cut_r;
  logic [OFF_W-1:0]   off_r;

  logic [CMD_W-1:0]   in_cmd;
  logic [SIZE_W-1:0]  in_size;
  logic [ADDR_W-1:0]  in_addr;
  logic [CLASS_W-1:0] in_cls;
  logic               accept;
  logic [LINK_W-1:0]  head_cur;
  logic [BSZ_W-1:0]   bsz;
  logic               carve_last;
  logic               out_free;

  logic [LINK_W-1:0]  link_mem [2**SLOT_W];
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [LINK_W-1:0]  mem_rdata_r;

  assign in_cmd  = in_tdata[CMD_W-1:0];
  assign in_size = in_tdata[CMD_W+SIZE_W-1:CMD_W];
  assign in_addr = in_tdata[CMD_W+SIZE_W+ADDR_W-1:CMD_W+SIZE_W];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - ADDR_W - STAT_W)'(0), out_stat_r, out_addr_r};

  // Class index is the number of class sizes below the request.
  always_comb begin
    in_cls = '0;
    for (int c = 0; c < NUM_CLASSES - 1; c++) begin
      if (in_size > SIZE_W'(CLASS_BYTES[c])) begin
        in_cls = in_cls + CLASS_W'(1);
      end
    end
  end

  assign head_cur   = heads_r[cls_r];
  assign bsz        = CLASS_BYTES[cls_r];
  assign carve_last = (off_r == CLASS_LAST_OFF[cls_r]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r[ADDR_W-1:4];
    mem_wdata = head_cur;
    mem_re    = 1'b0;
    if (state_r == S_EXEC && cmd_r == CMD_FREE && size_r != '0 &&
        size_r <= SIZE_W'(MAX_CLASS_BYTES)) begin
      mem_we = 1'b1;
    end
    if (state_r == S_EXEC && cmd_r == CMD_ALLOC && size_r != '0 &&
        size_r <= SIZE_W'(MAX_CLASS_BYTES) && !head_cur[ADDR_W]) begin
      mem_re = 1'b1;
    end
    if (state_r == S_CARVE) begin
      mem_we    = 1'b1;
      mem_waddr = cut_r[ADDR_W-1:4];
      mem_wdata = carve_last ? NULL_LINK : {1'b0, cut_r + ADDR_W'(bsz)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= link_mem[head_cur[ADDR_W-1:4]];
    end
  end

  // Sequencer and list heads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunks_r    <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        heads_r[c] <= NULL_LINK;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
          priority if (cmd_r == CMD_CLEAR) begin
            chunks_r <= '0;
            base_r   <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
              heads_r[c] <= NULL_LINK;
            end
          end else if (cmd_r == CMD_UNUSED || size_r == '0 ||
                       size_r > SIZE_W'(MAX_CLASS_BYTES)) begin
            state_r <= S_DONE;
          end else if (cmd_r == CMD_FREE) begin
            heads_r[cls_r] <= {1'b0, addr_r};
          end else if (!head_cur[ADDR_W]) begin
            state_r <= S_POP;
          end else if (chunks_r < CNT_W'(MAX_CHUNKS)) begin
            state_r <= S_CARVE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_POP: begin
          heads_r[cls_r] <= mem_rdata_r;
          state_r        <= S_DONE;
        end
        S_CARVE: begin
          if (carve_last) begin
            heads_r[cls_r] <= (CLASS_LAST_OFF[cls_r] == '0) ? NULL_LINK :
                              {1'b0, base_r + ADDR_W'(bsz)};
            chunks_r <= chunks_r + CNT_W'(1);
            base_r   <= base_r + ADDR_W'(CHUNK_BYTES);
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Command fields, result word and carve cursor.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      size_r <= in_size;
      addr_r <= in_addr;
      cls_r  <= in_cls;
    end
    if (state_r == S_EXEC) begin
      res_addr_r <= '0;
      cut_r      <= base_r;
      off_r      <= '0;
      priority if (cmd_r == CMD_CLEAR) begin
        res_stat_r <= ST_CLEARED;
      end else if (cmd_r == CMD_UNUSED || size_r == '0) begin
        res_stat_r <= ST_ZERO;
      end else if (size_r > SIZE_W'(MAX_CLASS_BYTES)) begin
        res_stat_r <= ST_OVERSIZE;
      end else if (cmd_r == CMD_FREE) begin
        res_stat_r <= ST_FREED;
      end else if (!head_cur[ADDR_W]) begin
        res_addr_r <= head_cur[ADDR_W-1:0];
        res_stat_r <= ST_ALLOCATED;
      end else if (chunks_r < CNT_W'(MAX_CHUNKS)) begin
        res_addr_r <= base_r;
        res_stat_r <= ST_ALLOCATED;
      end else begin
        res_stat_r <= ST_EXHAUSTED;
      end
    end
    if (state_r == S_CARVE) begin
      cut_r <= cut_r + ADDR_W'(bsz);
      off_r <= off_r + OFF_W'(bsz);
    end
    if (state_r == S_DONE && out_free) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import scba_pkg::*;

  localparam int RANDOM_ITEMS  = 120;
  localparam int CALM_ITEMS    = 40;
  localparam int STALL_CYCLES  = 400;
  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam int BIG_CLASS     = NUM_CLASSES - 1;
  localparam int DUMP_CLASS    = NUM_CLASSES - 2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } live_block_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the allocator state.
  logic [LINK_W-1:0] heads_m [NUM_CLASSES];
  logic [LINK_W-1:0] links_m [1 << SLOT_W];
  int unsigned       chunks_m;

  alloc_result_t expected_results [$];
  int unsigned   mismatch_count;
  int unsigned   status_seen [8];
  int unsigned   words_sent;
  int unsigned   cycle_count;
  int            idle_pct = 36;
  bit            stall_request;

  size_class_block_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_results.size());
    $display("tb NOT OK");
    $finish;
  end

  function automatic logic [SLOT_W-1:0] link_index(logic [ADDR_W-1:0] addr);
    return addr[ADDR_W-1:4];
  endfunction

  function automatic int unsigned class_for(logic [SIZE_W-1:0] size);
    int unsigned c = 0;
    while (c + 1 < NUM_CLASSES && size > CLASS_BYTES[c]) c++;
    return c;
  endfunction

  // Updates the shadow state for one accepted word and returns its result.
  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [SIZE_W-1:0] size,
                                                  logic [ADDR_W-1:0] addr);
    alloc_result_t     res;
    int unsigned       c;
    int unsigned       bsz;
    int unsigned       count;
    logic [ADDR_W-1:0] base;
    res.addr = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (heads_m[i]) heads_m[i] = NULL_LINK;
      chunks_m = 0;
      res.status = ST_CLEARED;
    end else if (cmd == CMD_UNUSED || size == 0) begin
      res.status = ST_ZERO;
    end else if (size > MAX_CLASS_BYTES) begin
      res.status = ST_OVERSIZE;
    end else if (cmd == CMD_FREE) begin
      c = class_for(size);
      links_m[link_index(addr)] = heads_m[c];
      heads_m[c] = {1'b0, addr};
      res.status = ST_FREED;
    end else begin
      c = class_for(size);
      if (!heads_m[c][ADDR_W]) begin
        res.addr = heads_m[c][ADDR_W-1:0];
        heads_m[c] = links_m[link_index(res.addr)];
        res.status = ST_ALLOCATED;
      end else if (chunks_m >= MAX_CHUNKS) begin
        res.status = ST_EXHAUSTED;
      end else begin
        bsz = CLASS_BYTES[c];
        count = CHUNK_BYTES / bsz;
        base = ADDR_W'(chunks_m * CHUNK_BYTES);
        for (int i = 0; i + 1 < count; i++) begin
          links_m[link_index(ADDR_W'(base + i * bsz))] = {1'b0, ADDR_W'(base + (i + 1) * bsz)};
        end
        links_m[link_index(ADDR_W'(base + (count - 1) * bsz))] = NULL_LINK;
        heads_m[c] = links_m[link_index(base)];
        chunks_m++;
        res.addr = base;
        res.status = ST_ALLOCATED;
      end
    end
    return res;
  endfunction

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr, output alloc_result_t res);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - CMD_W - SIZE_W - ADDR_W){1'b0}}, addr, size, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = apply_command(cmd, size, addr);
    expected_results.push_back(res);
    words_sent++;
  endtask

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  // Result side: random back-pressure plus the long hold-off on request.
  initial begin
    alloc_result_t want;
    int            stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        status_seen[out_tdata[ADDR_W +: STAT_W]]++;
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected word %h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[ADDR_W +: STAT_W] != want.status)
            note_mismatch($sformatf("status expected %0d, got %0d", want.status,
                                    out_tdata[ADDR_W +: STAT_W]));
          if (out_tdata[ADDR_W-1:0] != want.addr)
            note_mismatch($sformatf("address expected %h, got %h", want.addr,
                                    out_tdata[ADDR_W-1:0]));
          if (out_tdata[OUT_DATA_W-1:ADDR_W+STAT_W] != '0)
            note_mismatch($sformatf("padding bits set in %h", out_tdata));
        end
      end
      if (stall_request) begin
        stall_request = 1'b0;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned c  = $urandom_range(0, NUM_CLASSES - 1);
    int unsigned lo = (c == 0) ? 1 : CLASS_BYTES[c-1] + 1;
    int unsigned hi = CLASS_BYTES[c];
    case ($urandom_range(0, 3))
      0:       return SIZE_W'(lo);
      1:       return SIZE_W'(hi);
      default: return SIZE_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic test_directed_cases();
    alloc_result_t r;
    send_command(CMD_CLEAR, '0, '0, r);
    send_command(CMD_ALLOC, 16'd1, '0, r);
    send_command(CMD_ALLOC, 16'd16, '0, r);
    send_command(CMD_ALLOC, 16'd17, '0, r);
    send_command(CMD_FREE, 16'd16, 20'h00010, r);
    send_command(CMD_ALLOC, 16'd16, '0, r);
    send_command(CMD_ALLOC, '0, 20'hFFFFF, r);
    send_command(CMD_FREE, '0, 20'h00020, r);
    send_command(CMD_ALLOC, 16'd641, '0, r);
    send_command(CMD_FREE, 16'hFFFF, 20'hFFFFF, r);
    send_command(CMD_UNUSED, 16'd100, '0, r);
    send_command(CMD_UNUSED, 16'hFFFF, 20'hFFFFF, r);
    // An unaligned address at the top of the space is pushed as given.
    send_command(CMD_FREE, 16'd300, 20'hFFFFF, r);
    send_command(CMD_ALLOC, 16'd300, '0, r);
    for (int c = 2; c < NUM_CLASSES; c++) begin
      send_command(CMD_ALLOC, SIZE_W'(CLASS_BYTES[c]), '0, r);
    end
  endtask

  task automatic test_pool_exhaustion();
    alloc_result_t r;
    send_command(CMD_CLEAR, '0, '0, r);
    // Each pass carves one chunk, then re-frees the second block into an empty
    // class so that its link ends the big list and both lists drain in two pops.
    while (chunks_m < MAX_CHUNKS) begin
      send_command(CMD_ALLOC, SIZE_W'(CLASS_BYTES[BIG_CLASS]), '0, r);
      send_command(CMD_FREE, SIZE_W'(CLASS_BYTES[DUMP_CLASS]),
                   heads_m[BIG_CLASS][ADDR_W-1:0], r);
      send_command(CMD_ALLOC, SIZE_W'(CLASS_BYTES[BIG_CLASS]), '0, r);
      send_command(CMD_ALLOC, SIZE_W'(CLASS_BYTES[DUMP_CLASS]), '0, r);
    end
    send_command(CMD_ALLOC, SIZE_W'(CLASS_BYTES[BIG_CLASS]), '0, r);
    send_command(CMD_ALLOC, 16'd1, '0, r);
    send_command(CMD_FREE, 16'd16, 20'h00040, r);
    send_command(CMD_ALLOC, 16'd16, '0, r);
    send_command(CMD_ALLOC, 16'd16, '0, r);
    send_command(CMD_CLEAR, '0, '0, r);
    send_command(CMD_ALLOC, 16'd16, '0, r);
  endtask

  task automatic test_output_stall();
    alloc_result_t r;
    idle_pct = 0;
    stall_request = 1'b1;
    repeat (8) begin
      send_command(CMD_ALLOC, 16'd32, '0, r);
      send_command(CMD_FREE, 16'd32, r.addr, r);
    end
    idle_pct = 36;
  endtask

  task automatic test_random_traffic();
    alloc_result_t     r;
    live_block_t       blk;
    live_block_t       live [$];
    logic [SIZE_W-1:0] sz;
    int unsigned       pick;
    int unsigned       idx;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n < CALM_ITEMS) ? 0 : 36;
      pick = $urandom_range(0, 99);
      if (pick < 40 || (pick < 76 && live.size() == 0)) begin
        sz = pick_size();
        send_command(CMD_ALLOC, sz, ADDR_W'($urandom), r);
        if (r.status == ST_ALLOCATED) begin
          blk.addr = r.addr;
          blk.size = sz;
          live.push_back(blk);
        end
      end else if (pick < 76) begin
        idx = $urandom_range(0, live.size() - 1);
        blk = live[idx];
        // Now and then the block stays listed, so that it can later be freed twice.
        if ($urandom_range(0, 19) != 0) live.delete(idx);
        send_command(CMD_FREE, blk.size, blk.addr, r);
      end else if (pick < 84) begin
        send_command(CMD_FREE, SIZE_W'($urandom_range(1, MAX_CLASS_BYTES)),
                     ADDR_W'($urandom), r);
      end else if (pick < 89) begin
        send_command($urandom_range(0, 1) ? CMD_FREE : CMD_ALLOC, '0, ADDR_W'($urandom), r);
      end else if (pick < 95) begin
        send_command($urandom_range(0, 1) ? CMD_FREE : CMD_ALLOC,
                     SIZE_W'($urandom_range(MAX_CLASS_BYTES + 1, 65535)), ADDR_W'($urandom), r);
      end else if (pick < 98) begin
        send_command(CMD_UNUSED, SIZE_W'($urandom), ADDR_W'($urandom), r);
      end else begin
        send_command(CMD_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom), r);
        live.delete();
      end
    end
  endtask

  initial begin
    foreach (heads_m[i]) heads_m[i] = NULL_LINK;
    chunks_m = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_pool_exhaustion();
    test_output_stall();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d words sent: %0d allocations, %0d frees, %0d clears, %0d pool exhausted,",
             words_sent, status_seen[ST_ALLOCATED], status_seen[ST_FREED],
             status_seen[ST_CLEARED], status_seen[ST_EXHAUSTED]);
    $display("%0d zero-size or unused, %0d oversize; %0d mismatches in %0d cycles",
             status_seen[ST_ZERO], status_seen[ST_OVERSIZE], mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/scba_pkg.sv
sv/size_class_block_allocator.sv
sim/tb.sv
